/* design/pps_pkg.sv */
// ----------------------------------------------------------------------------
// pps_pkg: shared definitions for the priority scheduler
// Widths of the channel fields, codes, FSM states and the command and status
// groups between controller and datapath.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_PROCS_DEF = 16;
  localparam int TIME_BITS_DEF = 16;
  localparam int PRIO_BITS_DEF = 8;

  // Fixed field widths of the channels and the register port
  localparam int SLOT_W  = 4;
  localparam int TIME_W  = 16;
  localparam int PRIO_W  = 8;
  localparam int COUNT_W = 5;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  // Register select, taken from paddr[2]
  localparam logic REG_ENTRY_COUNT   = 1'b0;
  localparam logic REG_PRIORITY_MODE = 1'b1;

  // Priority modes
  localparam logic MODE_LOW_WINS  = 1'b0;
  localparam logic MODE_HIGH_WINS = 1'b1;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_TICK = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } in_item_t;

  typedef struct packed {
    logic              idle;
    logic [SLOT_W-1:0] run_slot;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } out_item_t;

  typedef struct packed {
    logic load;        // write the addressed table entry
    logic scan_start;  // clear scan index and best candidate
    logic scan_rd;     // read the entry at the scan index, advance it
    logic calc;        // retire one work unit, advance time
    logic emit;        // load the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic scan_end;    // scan index reached the slot count
    logic out_free;    // output register can take a result
  } ctrl_sts_t;

endpackage

/* design/pps_if.sv */
// ----------------------------------------------------------------------------
// pps_if: valid/ready channels of the priority scheduler
// One interface for the input items and one for the result items.
// ----------------------------------------------------------------------------
interface pps_in_if;
  logic                         valid;
  logic                         ready;
  pps_pkg::cmd_t                cmd;
  logic [pps_pkg::SLOT_W-1:0]   slot;
  logic [pps_pkg::TIME_W-1:0]   arrival;
  logic [pps_pkg::TIME_W-1:0]   burst;
  logic [pps_pkg::PRIO_W-1:0]   prio;

  modport source (output valid, output cmd, output slot, output arrival,
                  output burst, output prio, input ready);
  modport sink   (input valid, input cmd, input slot, input arrival,
                  input burst, input prio, output ready);
endinterface

interface pps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         idle;
  logic [pps_pkg::SLOT_W-1:0]   run_slot;
  logic                         finished;
  logic [pps_pkg::TIME_W-1:0]   completion_time;
  logic [pps_pkg::TIME_W-1:0]   turnaround;
  logic [pps_pkg::TIME_W-1:0]   waiting;
  logic                         all_done;

  modport source (output valid, output idle, output run_slot, output finished,
                  output completion_time, output turnaround, output waiting,
                  output all_done, input ready);
  modport sink   (input valid, input idle, input run_slot, input finished,
                  input completion_time, input turnaround, input waiting,
                  input all_done, output ready);
endinterface

/* design/pps_ctrl.sv */
// ----------------------------------------------------------------------------
// pps_ctrl: scheduler sequencer
// Takes loads without leaving idle; walks a tick through scan, update and emit.
// ----------------------------------------------------------------------------
module pps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  pps_pkg::cmd_t      in_cmd,
  output logic               in_ready,
  input  pps_pkg::ctrl_sts_t sts,
  output pps_pkg::ctrl_cmd_t cmd
);

  pps_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pps_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      pps_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_cmd == pps_pkg::CMD_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = pps_pkg::ST_SCAN;
          end
        end
      end
      pps_pkg::ST_SCAN: begin
        // last read is compared in the cycle that sees scan_end
        if (sts.scan_end) begin
          state_nxt = pps_pkg::ST_CALC;
        end else begin
          cmd.scan_rd = 1'b1;
        end
      end
      pps_pkg::ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = pps_pkg::ST_EMIT;
      end
      pps_pkg::ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = pps_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = pps_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* design/pps_dp.sv */
// ----------------------------------------------------------------------------
// pps_dp: scheduler datapath
// Process tables, scan comparator, time counter and the result register.
// ----------------------------------------------------------------------------
module pps_dp #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pps_pkg::ctrl_cmd_t          cmd,
  output pps_pkg::ctrl_sts_t          sts,
  input  pps_pkg::in_item_t           in_item,
  input  logic [pps_pkg::COUNT_W-1:0] entry_count,
  input  logic                        priority_mode,
  output logic                        out_valid,
  input  logic                        out_ready,
  output pps_pkg::out_item_t          out_item
);

  localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W  = $clog2(MAX_PROCS + 1);
  localparam int OUT_TW = pps_pkg::TIME_W;
  localparam int OUT_SW = pps_pkg::SLOT_W;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

  // Tables
  logic [TIME_BITS-1:0] arr_mem [MAX_PROCS];
  logic [TIME_BITS-1:0] bst_mem [MAX_PROCS];
  logic [TIME_BITS-1:0] rem_mem [MAX_PROCS];
  logic [PRIO_BITS-1:0] pri_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] rem_vld_r;

  // Scan read stage
  logic [CNT_W-1:0]     idx_r;
  logic                 pv_r;
  logic [IDX_W-1:0]     rd_idx_r;
  logic [TIME_BITS-1:0] rd_arr_r, rd_bst_r, rd_rem_r;
  logic [PRIO_BITS-1:0] rd_pri_r;
  logic                 rd_rvld_r;

  // Best candidate
  logic                 best_found_r;
  logic [IDX_W-1:0]     best_idx_r;
  logic [TIME_BITS-1:0] best_arr_r, best_bst_r, best_rem_r;
  logic [PRIO_BITS-1:0] best_pri_r;
  logic [1:0]           nz_cnt_r;

  // Update stage
  logic [TIME_BITS-1:0] time_r;
  logic [TIME_BITS-1:0] comp_r, tat_r;
  logic                 fin_r, done_r;

  logic                 out_valid_r;
  pps_pkg::out_item_t   out_item_r, out_item_nxt;

  logic                 slot_ok, ld_we;
  logic [IDX_W-1:0]     ld_idx, rd_addr;
  logic [CNT_W-1:0]     n_use;
  logic [TIME_BITS-1:0] rem_eff, rem_dec, time_inc, tat_calc, wt_calc;
  logic                 cand_ready, better, take, fin_calc, done_calc;

  assign slot_ok = int'(in_item.slot) < MAX_PROCS;
  assign ld_we   = cmd.load && slot_ok;
  assign ld_idx  = IDX_W'(in_item.slot);
  assign rd_addr = idx_r[IDX_W-1:0];

  always_comb begin
    if (int'(entry_count) > MAX_PROCS) begin
      n_use = CNT_W'(MAX_PROCS);
    end else begin
      n_use = CNT_W'(entry_count);
    end
  end

  assign sts.scan_end = (idx_r == n_use);
  assign sts.out_free = !out_valid_r || out_ready;

  // Compare the entry read last cycle against the best so far
  assign rem_eff    = rd_rvld_r ? rd_rem_r : '0;
  assign cand_ready = (rd_arr_r <= time_r) && (rem_eff != '0);

  always_comb begin
    if (!best_found_r) begin
      better = 1'b1;
    end else if (priority_mode == pps_pkg::MODE_LOW_WINS) begin
      better = (rd_pri_r < best_pri_r) ||
               ((rd_pri_r == best_pri_r) && (rd_arr_r < best_arr_r));
    end else begin
      better = rd_pri_r > best_pri_r;
    end
  end

  assign take = pv_r && cand_ready && better;

  // Retire one unit of the chosen entry
  assign rem_dec   = best_rem_r - 1'b1;
  assign time_inc  = (time_r == TIME_MAX) ? time_r : time_r + 1'b1;
  assign fin_calc  = best_found_r && (rem_dec == '0);
  assign tat_calc  = (time_inc >= best_arr_r) ? time_inc - best_arr_r : '0;
  assign done_calc = (nz_cnt_r == 2'd0) || ((nz_cnt_r == 2'd1) && fin_calc);
  assign wt_calc   = (tat_r >= best_bst_r) ? tat_r - best_bst_r : '0;

  always_comb begin
    out_item_nxt                 = '0;
    out_item_nxt.idle            = !best_found_r;
    out_item_nxt.run_slot        = best_found_r ? OUT_SW'(best_idx_r) : '0;
    out_item_nxt.finished        = fin_r;
    out_item_nxt.completion_time = fin_r ? OUT_TW'(comp_r) : '0;
    out_item_nxt.turnaround      = fin_r ? OUT_TW'(tat_r) : '0;
    out_item_nxt.waiting         = fin_r ? OUT_TW'(wt_calc) : '0;
    out_item_nxt.all_done        = done_r;
  end

  // Table storage and registered reads
  always_ff @(posedge clk) begin
    if (ld_we) begin
      arr_mem[ld_idx] <= TIME_BITS'(in_item.arrival);
      bst_mem[ld_idx] <= TIME_BITS'(in_item.burst);
      pri_mem[ld_idx] <= PRIO_BITS'(in_item.prio);
      rem_mem[ld_idx] <= TIME_BITS'(in_item.burst);
    end else if (cmd.calc && best_found_r) begin
      rem_mem[best_idx_r] <= rem_dec;
    end
    if (cmd.scan_rd) begin
      rd_arr_r  <= arr_mem[rd_addr];
      rd_bst_r  <= bst_mem[rd_addr];
      rd_rem_r  <= rem_mem[rd_addr];
      rd_pri_r  <= pri_mem[rd_addr];
      rd_rvld_r <= rem_vld_r[rd_addr];
      rd_idx_r  <= rd_addr;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      best_idx_r <= rd_idx_r;
      best_arr_r <= rd_arr_r;
      best_bst_r <= rd_bst_r;
      best_rem_r <= rem_eff;
      best_pri_r <= rd_pri_r;
    end
    if (cmd.calc) begin
      comp_r <= time_inc;
      tat_r  <= tat_calc;
      fin_r  <= fin_calc;
      done_r <= done_calc;
    end
    if (cmd.emit) begin
      out_item_r <= out_item_nxt;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_vld_r    <= '0;
      idx_r        <= '0;
      pv_r         <= 1'b0;
      best_found_r <= 1'b0;
      nz_cnt_r     <= 2'd0;
      time_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      pv_r <= cmd.scan_rd;
      if (ld_we) begin
        rem_vld_r[ld_idx] <= 1'b1;
      end
      if (cmd.scan_start) begin
        idx_r        <= '0;
        best_found_r <= 1'b0;
        nz_cnt_r     <= 2'd0;
      end else begin
        if (cmd.scan_rd) begin
          idx_r <= idx_r + 1'b1;
        end
        if (take) begin
          best_found_r <= 1'b1;
        end
        // count busy slots, saturating at two
        if (pv_r && (rem_eff != '0) && (nz_cnt_r != 2'd2)) begin
          nz_cnt_r <= nz_cnt_r + 2'd1;
        end
      end
      if (cmd.calc) begin
        time_r <= time_inc;
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

/* design/preemptive_priority_scheduler.sv */
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler: one-unit-per-tick priority scheduler
// Process table with an APB register port and valid/ready item channels.
// ----------------------------------------------------------------------------
// A load item (cmd 0) writes one process slot and gives no result; slots at
// or above MAX_PROCS are dropped. A tick item (cmd 1) is accepted, then the
// scan walks the first n slots, where n is entry_count clamped to MAX_PROCS,
// through the single scan comparator fed by the registered table read,
// finishes the last compare, retires the work unit and advances time, and
// loads the result register once it is free. A result waits in that register
// while the next item is already accepted. Registers: entry_count at byte 0x0,
// priority_mode at 0x4; write them only while no tick is in flight.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler #(
  parameter int MAX_PROCS = pps_pkg::MAX_PROCS_DEF,
  parameter int TIME_BITS = pps_pkg::TIME_BITS_DEF,
  parameter int PRIO_BITS = pps_pkg::PRIO_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  pps_in_if.sink                     in_ch,
  pps_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pps_pkg::ADDR_W-1:0] paddr,
  input  logic [pps_pkg::DATA_W-1:0] pwdata,
  output logic [pps_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  localparam int CW = pps_pkg::COUNT_W;
  localparam int DW = pps_pkg::DATA_W;

  // Configuration registers
  logic [CW-1:0] cfg_entry_count_r;
  logic          cfg_priority_mode_r;
  logic          cfg_wr;

  pps_pkg::ctrl_cmd_t ctrl_cmd;
  pps_pkg::ctrl_sts_t ctrl_sts;
  pps_pkg::in_item_t  in_item;
  pps_pkg::out_item_t out_item;

  // Zero-wait-state port: a write lands on the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_entry_count_r   <= '0;
      cfg_priority_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[2])
        pps_pkg::REG_ENTRY_COUNT:   cfg_entry_count_r   <= pwdata[CW-1:0];
        pps_pkg::REG_PRIORITY_MODE: cfg_priority_mode_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      pps_pkg::REG_ENTRY_COUNT:   prdata = DW'(cfg_entry_count_r);
      pps_pkg::REG_PRIORITY_MODE: prdata = DW'(cfg_priority_mode_r);
      default:                    prdata = '0;
    endcase
  end

  // Gather the input transfer payload
  assign in_item.cmd     = in_ch.cmd;
  assign in_item.slot    = in_ch.slot;
  assign in_item.arrival = in_ch.arrival;
  assign in_item.burst   = in_ch.burst;
  assign in_item.prio    = in_ch.prio;

  pps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_cmd   (in_ch.cmd),
    .in_ready (in_ch.ready),
    .sts      (ctrl_sts),
    .cmd      (ctrl_cmd)
  );

  pps_dp #(
    .MAX_PROCS (MAX_PROCS),
    .TIME_BITS (TIME_BITS),
    .PRIO_BITS (PRIO_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (ctrl_cmd),
    .sts           (ctrl_sts),
    .in_item       (in_item),
    .entry_count   (cfg_entry_count_r),
    .priority_mode (cfg_priority_mode_r),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_item      (out_item)
  );

  // Drive the result transfer payload
  assign out_ch.idle            = out_item.idle;
  assign out_ch.run_slot        = out_item.run_slot;
  assign out_ch.finished        = out_item.finished;
  assign out_ch.completion_time = out_item.completion_time;
  assign out_ch.turnaround      = out_item.turnaround;
  assign out_ch.waiting         = out_item.waiting;
  assign out_ch.all_done        = out_item.all_done;

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for preemptive_priority_scheduler
// Drives load and tick items over the valid/ready input channel, programs
// the APB registers between phases and checks every tick result against a
// cycle-free model of the scheduler held in a small scoreboard class.
// ----------------------------------------------------------------------------
module testbench;
  import pps_pkg::*;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 8;
  localparam int SLOTS         = MAX_PROCS_DEF;
  localparam int HOLD_CYCLES   = 400;   // long receiver hold-off for back-pressure
  localparam int SETTLE_CYCLES = 30;    // settle margin after the last expected result
  localparam int STALL_LIMIT   = 4000;  // cycles without any transfer before giving up
  localparam int REPORT_MAX    = 10;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 60;

  localparam logic [ADDR_W-1:0] ADDR_ENTRY_COUNT   = {REG_ENTRY_COUNT, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_PRIORITY_MODE = {REG_PRIORITY_MODE, 2'b00};
  localparam logic [TIME_W-1:0] TIME_MAX           = '1;

  // --------------------------------------------------------------------------
  // Scheduler model and result checker
  // --------------------------------------------------------------------------
  class sched_checker;
    bit [TIME_W-1:0] arr_tab [SLOTS];
    bit [TIME_W-1:0] rem_tab [SLOTS];
    bit [TIME_W-1:0] bur_tab [SLOTS];
    bit [PRIO_W-1:0] pri_tab [SLOTS];
    bit [TIME_W-1:0] now;
    int              used;
    bit              mode;
    out_item_t       expected_ticks [$];
    int              failures;

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        arr_tab[i] = '0;
        rem_tab[i] = '0;
        bur_tab[i] = '0;
        pri_tab[i] = '0;
      end
      now      = '0;
      used     = 0;
      mode     = MODE_LOW_WINS;
      failures = 0;
    endfunction

    function void set_entry_count(logic [COUNT_W-1:0] count);
      used = (count > SLOTS) ? SLOTS : int'(count);
    endfunction

    function void set_mode(logic m);
      mode = m;
    endfunction

    function int ticks_owed();
      return expected_ticks.size();
    endfunction

    function void fail(string msg);
      failures++;
      if (failures <= REPORT_MAX) $display("ERROR: %s", msg);
    endfunction

    function string show(out_item_t r);
      return $sformatf("idle=%0d slot=%0d fin=%0d comp=%0d tat=%0d wait=%0d done=%0d",
                       r.idle, r.run_slot, r.finished, r.completion_time,
                       r.turnaround, r.waiting, r.all_done);
    endfunction

    // Update the tables for a load; for a tick, pick the winner, retire one
    // unit of its work and queue the result the block must produce.
    function void note_item(in_item_t it);
      int              best;
      bit              better;
      bit [TIME_W-1:0] tat;
      out_item_t       res;
      if (it.cmd == CMD_LOAD) begin
        arr_tab[it.slot] = it.arrival;
        bur_tab[it.slot] = it.burst;
        rem_tab[it.slot] = it.burst;
        pri_tab[it.slot] = it.prio;
        return;
      end
      best   = -1;
      better = 1'b0;
      for (int i = 0; i < used; i++) begin
        if (arr_tab[i] > now || rem_tab[i] == 0) continue;
        if (best < 0) begin
          better = 1'b1;
        end else if (mode == MODE_LOW_WINS) begin
          better = (pri_tab[i] < pri_tab[best]) ||
                   (pri_tab[i] == pri_tab[best] && arr_tab[i] < arr_tab[best]);
        end else begin
          better = pri_tab[i] > pri_tab[best];
        end
        if (better) best = i;
      end
      // Time sticks at its maximum
      if (now != TIME_MAX) now++;
      res = '0;
      if (best < 0) begin
        res.idle = 1'b1;
      end else begin
        res.run_slot = best[SLOT_W-1:0];
        rem_tab[best]--;
        if (rem_tab[best] == 0) begin
          res.finished        = 1'b1;
          res.completion_time = now;
          tat = (now >= arr_tab[best]) ? now - arr_tab[best] : '0;
          res.turnaround      = tat;
          res.waiting         = (tat >= bur_tab[best]) ? tat - bur_tab[best] : '0;
        end
      end
      res.all_done = 1'b1;
      for (int i = 0; i < used; i++)
        if (rem_tab[i] != 0) res.all_done = 1'b0;
      expected_ticks.push_back(res);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      string     diffs;
      if (expected_ticks.size() == 0) begin
        fail({"result with nothing expected: ", show(got)});
        return;
      end
      want  = expected_ticks.pop_front();
      diffs = "";
      if (got.idle !== want.idle)                       diffs = {diffs, " idle"};
      if (got.run_slot !== want.run_slot)               diffs = {diffs, " run_slot"};
      if (got.finished !== want.finished)               diffs = {diffs, " finished"};
      if (got.completion_time !== want.completion_time) diffs = {diffs, " completion_time"};
      if (got.turnaround !== want.turnaround)           diffs = {diffs, " turnaround"};
      if (got.waiting !== want.waiting)                 diffs = {diffs, " waiting"};
      if (got.all_done !== want.all_done)               diffs = {diffs, " all_done"};
      if (diffs != "")
        fail($sformatf("mismatch in%s\n  expected %s\n  actual   %s",
                       diffs, show(want), show(got)));
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic              clk;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bit quiet    = 1'b0;  // no idling on either side while set
  bit hold_req = 1'b0;  // ask the receiver for one long hold-off

  sched_checker sb;

  pps_in_if  in_ch ();
  pps_out_if out_ch ();

  preemptive_priority_scheduler DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: sample both channels at the edge, check results before noting
  // the input that transfers on the same edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor_blk
    in_item_t  it;
    out_item_t res;
    if (rst_n === 1'b1) begin
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        res.idle            = out_ch.idle;
        res.run_slot        = out_ch.run_slot;
        res.finished        = out_ch.finished;
        res.completion_time = out_ch.completion_time;
        res.turnaround      = out_ch.turnaround;
        res.waiting         = out_ch.waiting;
        res.all_done        = out_ch.all_done;
        sb.check_result(res);
      end
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
        it.cmd     = in_ch.cmd;
        it.slot    = in_ch.slot;
        it.arrival = in_ch.arrival;
        it.burst   = in_ch.burst;
        it.prio    = in_ch.prio;
        sb.note_item(it);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready pattern, plus one long hold-off on request so the
  // result register and the item in flight back up into the input channel
  // --------------------------------------------------------------------------
  initial begin
    int n;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when no transfer happens for too long
  // --------------------------------------------------------------------------
  initial begin
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) ||
          (psel === 1'b1 && penable === 1'b1))
        stuck_cycles = 0;
      else
        stuck_cycles++;
    end
    $display("testbench: FAIL");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Driver tasks; each is entered right after a rising edge
  // --------------------------------------------------------------------------

  // Offer one item, hold it until it transfers; valid stays high afterwards
  // so the next item can follow on the very next cycle.
  task automatic push_item(cmd_t cmd, logic [SLOT_W-1:0] slot,
                           logic [TIME_W-1:0] arrival, logic [TIME_W-1:0] burst,
                           logic [PRIO_W-1:0] prio);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.slot    <= slot;
    in_ch.arrival <= arrival;
    in_ch.burst   <= burst;
    in_ch.prio    <= prio;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  task automatic load_slot(logic [SLOT_W-1:0] slot, logic [TIME_W-1:0] arrival,
                           logic [TIME_W-1:0] burst, logic [PRIO_W-1:0] prio);
    push_item(CMD_LOAD, slot, arrival, burst, prio);
  endtask

  // The payload of a tick is don't-care: fill it with noise
  task automatic tick();
    push_item(CMD_TICK, SLOT_W'($urandom()), TIME_W'($urandom()),
              TIME_W'($urandom()), PRIO_W'($urandom()));
  endtask

  // Drop valid, wait for every expected result, then let the block settle
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    // let the monitor note the transfer on the edge just passed
    @(posedge clk);
    while (sb.ticks_owed() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access until pready
  task automatic cfg_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Program both registers; upper data bits carry noise the block must drop
  task automatic apply_config(int count, logic m);
    cfg_write(ADDR_ENTRY_COUNT, ($urandom() & ~32'h1F) | DATA_W'(count));
    sb.set_entry_count(COUNT_W'(count));
    cfg_write(ADDR_PRIORITY_MODE, ($urandom() & ~32'h1) | DATA_W'(m));
    sb.set_mode(m);
  endtask

  // Random traffic: mostly a burst of loads near the current time followed
  // by ticks for their work, up to eight per load, the rest single noise items.
  task automatic run_random(int budget);
    int              left;
    int              span;
    int              k;
    int              work;
    logic [TIME_W-1:0] arr;
    logic [TIME_W-1:0] bur;
    logic [PRIO_W-1:0] pr;
    left = budget;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        span = (sb.used > 0) ? sb.used : SLOTS;
        k    = $urandom_range(1, (span < 4) ? span : 4);
        work = 0;
        repeat (k) begin
          arr = TIME_W'(sb.now + $urandom_range(0, 4) - 2);
          if ($urandom_range(0, 7) == 0) arr = TIME_W'($urandom());
          bur = TIME_W'($urandom_range(1, 6));
          case ($urandom_range(0, 9))
            0: bur = '0;
            1: bur = TIME_W'($urandom());
            default: ;
          endcase
          // Small priorities make ties common
          pr = $urandom_range(0, 1) ? PRIO_W'($urandom()) : PRIO_W'($urandom_range(0, 3));
          load_slot(SLOT_W'($urandom_range(0, span - 1)), arr, bur, pr);
          work += (bur < 8) ? int'(bur) : 8;
          left--;
        end
        repeat (work + $urandom_range(0, 3)) begin
          tick();
          left--;
        end
        if ($urandom_range(0, 15) == 0) wait_drained();
      end else begin
        if ($urandom_range(0, 1))
          load_slot(SLOT_W'($urandom()), TIME_W'($urandom()), TIME_W'($urandom()),
                    PRIO_W'($urandom()));
        else
          tick();
        left--;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  int   phase_count [PHASES] = '{16, 16, 3, 31, 0, 2, 20, 9};
  logic phase_mode  [PHASES] = '{MODE_LOW_WINS, MODE_HIGH_WINS, MODE_LOW_WINS,
                                 MODE_HIGH_WINS, MODE_LOW_WINS, MODE_HIGH_WINS,
                                 MODE_HIGH_WINS, MODE_LOW_WINS};

  initial begin
    sb = new();
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_LOAD;
    in_ch.slot    <= '0;
    in_ch.arrival <= '0;
    in_ch.burst   <= '0;
    in_ch.prio    <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Lowest value wins: idle tick on an empty table, ties on priority and
    // arrival, an arrival tiebreak, a zero burst that never runs
    apply_config(4, MODE_LOW_WINS);
    tick();
    load_slot(0, 0, 2, 5);
    load_slot(1, 0, 1, 5);
    load_slot(2, 1, 1, 5);
    load_slot(3, 0, 0, 0);
    repeat (5) tick();
    // Field extremes: a slot that never arrives, then a reload that clears it
    load_slot(0, TIME_MAX, TIME_MAX, '1);
    load_slot(1, 0, 1, 0);
    repeat (2) tick();
    load_slot(0, 0, 0, 0);
    wait_drained();

    // Highest value wins: the top priority first, then ties by lower slot
    apply_config(3, MODE_HIGH_WINS);
    load_slot(0, 0, 1, 7);
    load_slot(1, 0, 1, 7);
    load_slot(2, 0, 1, '1);
    repeat (4) tick();
    wait_drained();

    // Random phases over several register settings, oversized count included
    for (int p = 0; p < PHASES; p++) begin
      apply_config(phase_count[p], phase_mode[p]);
      quiet = (p == 5);
      if (p == 2) begin
        // Hold the receiver off while ticks keep coming so the input stalls
        hold_req = 1'b1;
        repeat (12) tick();
      end
      run_random(PHASE_ITEMS);
      wait_drained();
    end

    if (sb.failures == 0 && sb.ticks_owed() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
